FILE: design/sncs_pkg.sv
// shared types, register map and status codes of the sparse coordinate store
package sncs_pkg;

  localparam int SNCS_MAX_DIMS   = 4;
  localparam int SNCS_CAPACITY   = 64;
  localparam int SNCS_COORD_BITS = 16;

  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_DIMS     = 3'd0;
  localparam logic [2:0] REG_EXTENT_0 = 3'd1;
  localparam logic [2:0] REG_EXTENT_1 = 3'd2;
  localparam logic [2:0] REG_EXTENT_2 = 3'd3;
  localparam logic [2:0] REG_EXTENT_3 = 3'd4;
  localparam logic [2:0] REG_DEFAULT  = 3'd5;

  localparam logic [2:0]  DIMS_RESET   = 3'd2;
  localparam logic [15:0] EXTENT_RESET = 16'd16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] coord_0;
    logic [15:0] coord_1;
    logic [15:0] coord_2;
    logic [15:0] coord_3;
    logic signed [31:0] cell_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] read_value;
    logic [6:0]  entries_held;
  } out_word_t;

  typedef struct packed {
    logic [2:0]       dims_in_use;
    logic [3:0][15:0] extent;
    logic signed [31:0] default_value;
  } cfg_t;

endpackage

FILE: design/sncs_regs.sv
// configuration registers behind the apb-style port
module sncs_regs
  import sncs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  table_empty,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dims_in_use   <= DIMS_RESET;
      cfg_r.extent        <= {4{EXTENT_RESET}};
      cfg_r.default_value <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DIMS:     cfg_r.dims_in_use <= pwdata[2:0];
        REG_EXTENT_0: cfg_r.extent[0]   <= pwdata[15:0];
        REG_EXTENT_1: cfg_r.extent[1]   <= pwdata[15:0];
        REG_EXTENT_2: cfg_r.extent[2]   <= pwdata[15:0];
        REG_EXTENT_3: cfg_r.extent[3]   <= pwdata[15:0];
        REG_DEFAULT: begin
          if (table_empty) begin
            cfg_r.default_value <= pwdata;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIMS:     prdata = 32'(cfg_r.dims_in_use);
      REG_EXTENT_0: prdata = 32'(cfg_r.extent[0]);
      REG_EXTENT_1: prdata = 32'(cfg_r.extent[1]);
      REG_EXTENT_2: prdata = 32'(cfg_r.extent[2]);
      REG_EXTENT_3: prdata = 32'(cfg_r.extent[3]);
      REG_DEFAULT:  prdata = cfg_r.default_value;
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: design/sncs_table.sv
// entry table: one write port, one read port with registered data
module sncs_table
  import sncs_pkg::*;
#(
  parameter int WIDTH = 97,
  parameter int DEPTH = SNCS_CAPACITY
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

FILE: design/sncs_engine.sv
// sequencer: clearing pass, range check, linear search and read-modify-write
module sncs_engine
  import sncs_pkg::*;
#(
  parameter int MAX_DIMS   = SNCS_MAX_DIMS,
  parameter int CAPACITY   = SNCS_CAPACITY,
  parameter int COORD_BITS = SNCS_COORD_BITS,
  parameter int AW         = $clog2(CAPACITY),
  parameter int EW         = MAX_DIMS * COORD_BITS + 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_word_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_word_t     out_data,
  output logic          table_empty,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [EW-1:0] mem_wr_data,
  output logic [AW-1:0] mem_rd_addr,
  input  logic [EW-1:0] mem_rd_data
);

  localparam int KW = MAX_DIMS * COORD_BITS;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t         state_r;
  in_word_t       item_r;
  logic [AW-1:0]  issue_idx_r;
  logic           issue_end_r;
  logic           pend_r;
  logic [AW-1:0]  pend_idx_r;
  logic           found_r;
  logic [AW-1:0]  found_idx_r;
  logic [EW-1:0]  found_word_r;
  logic           free_ok_r;
  logic [AW-1:0]  free_idx_r;
  logic [CW-1:0]  count_r;
  logic [1:0]     status_r;
  logic [31:0]    rv_r;
  logic           out_valid_r;
  out_word_t      out_word_r;

  logic [3:0][15:0] crd;
  logic [MAX_DIMS-1:0] dim_en;
  logic           out_of_range;
  logic           rd_match;
  logic [KW-1:0]  new_key;
  logic           is_read;
  logic           val_is_def;

  assign crd[0] = item_r.coord_0;
  assign crd[1] = item_r.coord_1;
  assign crd[2] = item_r.coord_2;
  assign crd[3] = item_r.coord_3;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_word_r;
  assign table_empty = (count_r == '0);
  assign is_read     = (item_r.action == ACT_READ);
  assign val_is_def  = (item_r.cell_value == cfg.default_value);
  assign mem_rd_addr = issue_idx_r;

  always_comb begin
    out_of_range = 1'b0;
    rd_match     = mem_rd_data[EW-1];
    new_key      = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      dim_en[i] = (i == 0) || (3'(i) < cfg.dims_in_use);
      new_key[i*COORD_BITS +: COORD_BITS] = crd[i][COORD_BITS-1:0];
      if (dim_en[i]) begin
        if ((crd[i] >= cfg.extent[i]) || ((32'(crd[i]) >> COORD_BITS) != 32'd0)) begin
          out_of_range = 1'b1;
        end
        if (mem_rd_data[i*COORD_BITS +: COORD_BITS] != crd[i][COORD_BITS-1:0]) begin
          rd_match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = issue_idx_r;
    mem_wr_data = '0;
    if (state_r == S_CLEAR) begin
      mem_wr_en = 1'b1;
    end else if ((state_r == S_UPDATE) && !is_read) begin
      if (found_r) begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = found_idx_r;
        if (val_is_def) begin
          mem_wr_data = '0;
        end else begin
          mem_wr_data = {1'b1, item_r.cell_value, found_word_r[KW-1:0]};
        end
      end else if (!val_is_def && free_ok_r) begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = free_idx_r;
        mem_wr_data = {1'b1, item_r.cell_value, new_key};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      issue_idx_r <= '0;
      issue_end_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (issue_idx_r == LAST_IDX) begin
            issue_idx_r <= '0;
            state_r     <= S_IDLE;
          end else begin
            issue_idx_r <= issue_idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (out_of_range) begin
            status_r <= STATUS_RANGE;
            rv_r     <= '0;
            state_r  <= S_DONE;
          end else begin
            issue_idx_r <= '0;
            issue_end_r <= 1'b0;
            pend_r      <= 1'b0;
            found_r     <= 1'b0;
            free_ok_r   <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue_end_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= issue_idx_r;
            if (issue_idx_r == LAST_IDX) begin
              issue_end_r <= 1'b1;
            end else begin
              issue_idx_r <= issue_idx_r + 1'b1;
            end
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (rd_match) begin
              found_r      <= 1'b1;
              found_idx_r  <= pend_idx_r;
              found_word_r <= mem_rd_data;
              state_r      <= S_UPDATE;
            end else begin
              if (!mem_rd_data[EW-1] && !free_ok_r) begin
                free_ok_r  <= 1'b1;
                free_idx_r <= pend_idx_r;
              end
              if (pend_idx_r == LAST_IDX) begin
                state_r <= S_UPDATE;
              end
            end
          end
        end
        S_UPDATE: begin
          status_r <= STATUS_OK;
          rv_r     <= '0;
          if (is_read) begin
            rv_r <= found_r ? found_word_r[KW +: 32] : cfg.default_value;
          end else if (found_r) begin
            if (val_is_def) begin
              count_r <= count_r - 1'b1;
            end
          end else if (!val_is_def) begin
            if (free_ok_r) begin
              count_r <= count_r + 1'b1;
            end else begin
              status_r <= STATUS_FULL;
            end
          end
          pend_r  <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_word_r.status       <= status_r;
            out_word_r.read_value   <= rv_r;
            out_word_r.entries_held <= 7'(count_r);
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/sparse_nd_coordinate_store_top.sv
// top level of the sparse n-dimensional coordinate store
//
// in channel (in_valid/in_ready/in_data) takes one word: a read or a write of
// one cell at up to four coordinates. out channel (out_valid/out_ready/
// out_data) returns one word per input word: status, read value and the
// number of entries held afterwards. apb-style port sets dims, extents and
// the default value; the default value only takes while the table is empty.
// one word is in flight at a time. an out-of-range word goes from the range
// check straight to its result; any other word scans the table one entry per
// cycle through the memory's single read port and then updates, finishing
// sooner when a match is found early. the next word can be accepted from the
// cycle in which the result shows. a finished result sits in the output
// register; the next word is accepted meanwhile and waits in its last step
// until out_ready frees the register. after reset the table is cleared one
// entry per cycle, with in_ready low; configuration writes are taken anytime.
module sparse_nd_coordinate_store_top
  import sncs_pkg::*;
#(
  parameter int MAX_DIMS   = SNCS_MAX_DIMS,
  parameter int CAPACITY   = SNCS_CAPACITY,
  parameter int COORD_BITS = SNCS_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = MAX_DIMS * COORD_BITS + 33;

  cfg_t          cfg;
  logic          table_empty;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [EW-1:0] mem_rd_data;

  sncs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .table_empty (table_empty),
    .cfg         (cfg)
  );

  sncs_table #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sncs_engine #(
    .MAX_DIMS   (MAX_DIMS),
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .EW         (EW)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .table_empty (table_empty),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

FILE: tb/sv/sncs_tb_pkg.sv
`timescale 1ns / 100ps
// shadow copy of the coordinate store that predicts and checks each result word
package sncs_tb_pkg;
  import sncs_pkg::*;

  class cell_store_shadow;
    logic [2:0]  dims;
    logic [15:0] extent [4];
    logic [31:0] dflt;
    logic [63:0] keys [SNCS_CAPACITY];
    logic [31:0] stored [SNCS_CAPACITY];
    bit          used [SNCS_CAPACITY];
    int unsigned held;
    out_word_t   expected_replies [$];
    int          mismatches;

    function new();
      dims = DIMS_RESET;
      foreach (extent[i]) extent[i] = EXTENT_RESET;
      dflt = '0;
      foreach (used[i]) begin
        used[i] = 1'b0;
        keys[i] = '0;
        stored[i] = '0;
      end
      held = 0;
      mismatches = 0;
    endfunction

    function int active_dims();
      if (dims == 3'd0) return 1;
      if (dims > SNCS_MAX_DIMS) return SNCS_MAX_DIMS;
      return dims;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_DIMS: dims = v[2:0];
        REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3: begin
          extent[idx - REG_EXTENT_0] = v[15:0];
        end
        REG_DEFAULT: begin
          if (held == 0) dflt = v;
        end
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_DIMS: return {29'd0, dims};
        REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3: begin
          return {16'd0, extent[idx - REG_EXTENT_0]};
        end
        REG_DEFAULT: return dflt;
        default: return '0;
      endcase
    endfunction

    function bit same_cell(logic [63:0] a, logic [63:0] b, int nd);
      for (int j = 0; j < nd; j++) begin
        if (a[16*j +: 16] != b[16*j +: 16]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // key of some held entry, or a random one while the table is empty
    function logic [63:0] held_key();
      int s;
      s = $urandom_range(0, SNCS_CAPACITY - 1);
      for (int n = 0; n < SNCS_CAPACITY; n++) begin
        if (used[(s + n) % SNCS_CAPACITY]) return keys[(s + n) % SNCS_CAPACITY];
      end
      return {$urandom, $urandom};
    endfunction

    function void take_word(in_word_t w);
      logic [63:0] k;
      out_word_t   e;
      int          nd;
      bit          ok;
      int          hit;
      int          slot;
      k = {w.coord_3, w.coord_2, w.coord_1, w.coord_0};
      nd = active_dims();
      ok = 1'b1;
      for (int i = 0; i < nd; i++) begin
        if (k[16*i +: 16] >= extent[i]) ok = 1'b0;
      end
      e.status = STATUS_OK;
      e.read_value = '0;
      if (!ok) begin
        e.status = STATUS_RANGE;
      end else begin
        hit = -1;
        for (int i = 0; i < SNCS_CAPACITY && hit < 0; i++) begin
          if (used[i] && same_cell(keys[i], k, nd)) hit = i;
        end
        if (w.action == ACT_READ) begin
          e.read_value = (hit >= 0) ? stored[hit] : dflt;
        end else if (hit >= 0) begin
          if (w.cell_value == dflt) begin
            used[hit] = 1'b0;
            held--;
          end else begin
            stored[hit] = w.cell_value;
          end
        end else if (w.cell_value != dflt) begin
          slot = -1;
          for (int i = 0; i < SNCS_CAPACITY && slot < 0; i++) begin
            if (!used[i]) slot = i;
          end
          if (slot < 0) begin
            e.status = STATUS_FULL;
          end else begin
            keys[slot] = k;
            stored[slot] = w.cell_value;
            used[slot] = 1'b1;
            held++;
          end
        end
      end
      e.entries_held = held[6:0];
      expected_replies.push_back(e);
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual status %0d value %0d held %0d",
                 $time, got.status, got.read_value, got.entries_held);
        return;
      end
      e = expected_replies.pop_front();
      if (got.status !== e.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      end
      if (got.read_value !== e.read_value) begin
        mismatches++;
        $display("%0t: read_value expected %0d actual %0d", $time, e.read_value,
                 got.read_value);
      end
      if (got.entries_held !== e.entries_held) begin
        mismatches++;
        $display("%0t: entries_held expected %0d actual %0d", $time, e.entries_held,
                 got.entries_held);
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/sparse_nd_coordinate_store_top_tb.sv
`timescale 1ns / 100ps
// testbench top for the sparse coordinate store: stimulus, handshakes and verdict
module sparse_nd_coordinate_store_top_tb;
  import sncs_pkg::*;
  import sncs_tb_pkg::*;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  cell_store_shadow shadow;

  sparse_nd_coordinate_store_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_word(out_data);
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.take_word(w);
  endtask

  task automatic send_cell(logic act, logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                           logic [15:0] c3, logic [31:0] v);
    in_word_t w;
    w.action = act;
    w.coord_0 = c0;
    w.coord_1 = c1;
    w.coord_2 = c2;
    w.coord_3 = c3;
    w.cell_value = v;
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write, then read back and compare
  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow.set_reg(idx, v);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== shadow.reg_value(idx)) begin
      shadow.mismatches++;
      $display("%0t: register %0d expected %h actual %h", $time, idx,
               shadow.reg_value(idx), prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_phase();
    int          r;
    logic [31:0] e;
    logic [31:0] dv;
    cfg_write(REG_DIMS, $urandom_range(0, 7));
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) e = 32'd65535;
      else if (r < 13) e = 32'd0;
      else if (r < 20) e = 32'd1;
      else e = $urandom_range(2, 24);
      cfg_write(3'(REG_EXTENT_0 + 3'(i)), e);
    end
    r = $urandom_range(0, 99);
    if (r < 15) dv = 32'h8000_0000;
    else if (r < 30) dv = 32'h7fff_ffff;
    else if (r < 50) dv = 32'd0;
    else dv = $urandom;
    cfg_write(REG_DEFAULT, dv);
  endtask

  // match on coord 0 alone so every held entry can be reached and removed
  task automatic drain_table();
    logic [63:0] k;
    cfg_write(REG_DIMS, 32'd1);
    cfg_write(REG_EXTENT_0, 32'd65535);
    while (shadow.held != 0) begin
      k = shadow.held_key();
      send_cell(ACT_WRITE, k[15:0], 16'($urandom), 16'($urandom), 16'($urandom),
                shadow.dflt);
    end
    wait_idle();
  endtask

  task automatic random_word();
    in_word_t    w;
    logic [63:0] k;
    logic [63:0] noise;
    int          r;
    int          nd;
    nd = shadow.active_dims();
    noise = {$urandom, $urandom};
    k = noise;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      k = shadow.held_key();
    end else if (r < 90) begin
      for (int i = 0; i < 4; i++) begin
        if (shadow.extent[i] != 16'd0) begin
          k[16*i +: 16] = 16'($urandom_range(0, shadow.extent[i] - 1));
        end
      end
    end else if (r < 95) begin
      k[15:0] = shadow.extent[0];
    end
    for (int i = nd; i < 4; i++) k[16*i +: 16] = noise[16*i +: 16];
    w.action = ($urandom_range(0, 99) < 40) ? ACT_READ : ACT_WRITE;
    {w.coord_3, w.coord_2, w.coord_1, w.coord_0} = k;
    r = $urandom_range(0, 99);
    if (r < 30) w.cell_value = shadow.dflt;
    else if (r < 34) w.cell_value = 32'h8000_0000;
    else if (r < 38) w.cell_value = 32'h7fff_ffff;
    else if (r < 42) w.cell_value = 32'hffff_ffff;
    else if (r < 45) w.cell_value = 32'd0;
    else w.cell_value = $urandom;
    send_word(w);
  endtask

  initial begin
    shadow = new();
    tx_idle_pct = 11;
    rx_idle_pct = 65;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_cell(ACT_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    send_cell(ACT_WRITE, 16'd15, 16'd15, 16'd0, 16'd0, 32'h7fff_ffff);
    send_cell(ACT_READ, 16'd15, 16'd15, 16'd0, 16'd0, 32'hffff_ffff);
    send_cell(ACT_WRITE, 16'd16, 16'd0, 16'd0, 16'd0, 32'd1);
    send_cell(ACT_READ, 16'd0, 16'd16, 16'd0, 16'd0, 32'd0);
    send_cell(ACT_WRITE, 16'd15, 16'd15, 16'd0, 16'd0, 32'h8000_0000);
    send_cell(ACT_WRITE, 16'd3, 16'd4, 16'd0, 16'd0, 32'd0);
    send_cell(ACT_WRITE, 16'd15, 16'd15, 16'hffff, 16'hffff, 32'd0);
    send_cell(ACT_READ, 16'd15, 16'd15, 16'd0, 16'd0, 32'd0);
    send_cell(ACT_WRITE, 16'd1, 16'd2, 16'd0, 16'd0, 32'd5);
    wait_idle();
    cfg_write(REG_DEFAULT, 32'd77);
    cfg_write(REG_DIMS, 32'd0);
    cfg_write(REG_EXTENT_0, 32'd65535);
    send_cell(ACT_READ, 16'd1, 16'd9, 16'd9, 16'd9, 32'd0);
    send_cell(ACT_WRITE, 16'd65534, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_cell(ACT_READ, 16'hffff, 16'd0, 16'd0, 16'd0, 32'd0);
    send_cell(ACT_READ, 16'd65534, 16'd0, 16'd0, 16'd0, 32'd0);
    wait_idle();
    cfg_write(REG_DIMS, 32'd7);
    cfg_write(REG_EXTENT_1, 32'd65535);
    cfg_write(REG_EXTENT_2, 32'd65535);
    cfg_write(REG_EXTENT_3, 32'd65535);
    send_cell(ACT_WRITE, 16'd65534, 16'd65534, 16'd65534, 16'd65534, 32'd1);
    send_cell(ACT_READ, 16'd65534, 16'hffff, 16'd65534, 16'd65534, 32'd0);
    send_cell(ACT_READ, 16'd65534, 16'd65534, 16'd65534, 16'd65534, 32'd0);
    wait_idle();
    cfg_write(REG_EXTENT_1, 32'd0);
    send_cell(ACT_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    send_cell(ACT_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3);
    wait_idle();
    // fill the table until inserts are refused
    cfg_write(REG_DIMS, 32'd1);
    cfg_write(REG_EXTENT_0, 32'd65535);
    for (int j = 0; j < SNCS_CAPACITY + 1; j++) begin
      send_cell(ACT_WRITE, 16'(j + 100), 16'd0, 16'd0, 16'd0, 32'(j + 1));
    end
    send_cell(ACT_READ, 16'd100, 16'd0, 16'd0, 16'd0, 32'd0);
    wait_idle();
    drain_table();
    cfg_write(REG_DEFAULT, 32'h8000_0000);

    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = (m == 0) ? 11 : (m == 1) ? 65 : 0;
      rx_idle_pct = (m == 0) ? 65 : (m == 1) ? 11 : 0;
      for (int p = 0; p < 6; p++) begin
        wait_idle();
        if (p % 3 == 0) drain_table();
        cfg_phase();
        repeat (60) random_word();
      end
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
